### hw/rtl/lsc_pkg.sv
// lsc_pkg: shared types and constants of the lap stopwatch controller
package lsc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_RUN      = 3'd1,
        MODE_RUN_LAP  = 3'd2,
        MODE_STOP     = 3'd3,
        MODE_STOP_LAP = 3'd4
    } mode_t;

    localparam logic [2:0] EV_STARTSTOP = 3'd2;
    localparam logic [2:0] EV_LAPRESET  = 3'd3;
    localparam logic [2:0] EV_LONG      = 3'd4;

    localparam logic [5:0] RATE_FAST = 6'd32;
    localparam logic [5:0] RATE_SLOW = 6'd2;
    localparam logic [5:0] RATE_LAP  = 6'd2;
    localparam logic [5:0] RATE_IDLE = 6'd1;

    // request after the mode update: shown time is minuend - subtrahend
    typedef struct packed {
        mode_t       mode;
        logic [31:0] minuend;
        logic [31:0] subtrahend;
        logic [6:0]  phase;
        logic        slow;
    } event_t;

endpackage

### hw/rtl/lsc_mode_ctrl.sv
// lsc_mode_ctrl: mode state machine, start/stop/lap marks and request capture
module lsc_mode_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_req_type,
    input  logic [31:0]         s_counter_now,
    input  logic [6:0]          s_tick_phase,
    output logic                evt_valid,
    input  logic                evt_ready,
    output lsc_pkg::event_t     evt
);

    lsc_pkg::mode_t  mode_reg, mode_next;
    logic [31:0]     start_reg, start_next;
    logic [31:0]     stop_reg, stop_next;
    logic [31:0]     lap_reg, lap_next;
    logic            slow_reg, slow_next;
    logic            evt_valid_reg;
    lsc_pkg::event_t evt_reg, evt_next;
    logic            accept;
    logic [31:0]     paused;

    assign s_ready   = !evt_valid_reg || evt_ready;
    assign accept    = s_valid && s_ready;
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;
    assign paused    = s_counter_now - stop_reg;

    // next state and marks
    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        lap_next   = lap_reg;
        slow_next  = slow_reg;
        unique case (mode_reg)
            lsc_pkg::MODE_IDLE: begin
                if (s_req_type == lsc_pkg::EV_STARTSTOP) begin
                    mode_next  = lsc_pkg::MODE_RUN;
                    start_next = s_counter_now;
                end else if (s_req_type == lsc_pkg::EV_LONG) begin
                    slow_next = !slow_reg;
                end
            end
            lsc_pkg::MODE_RUN: begin
                if (s_req_type == lsc_pkg::EV_STARTSTOP) begin
                    mode_next = lsc_pkg::MODE_STOP;
                    stop_next = s_counter_now;
                end else if (s_req_type == lsc_pkg::EV_LAPRESET) begin
                    mode_next = lsc_pkg::MODE_RUN_LAP;
                    lap_next  = s_counter_now;
                end
            end
            lsc_pkg::MODE_RUN_LAP: begin
                if (s_req_type == lsc_pkg::EV_STARTSTOP) begin
                    mode_next = lsc_pkg::MODE_STOP_LAP;
                    stop_next = s_counter_now;
                end else if (s_req_type == lsc_pkg::EV_LAPRESET) begin
                    mode_next = lsc_pkg::MODE_RUN;
                    lap_next  = s_counter_now;
                end else if (s_req_type == lsc_pkg::EV_LONG) begin
                    mode_next = lsc_pkg::MODE_RUN;
                    slow_next = !slow_reg;
                end
            end
            lsc_pkg::MODE_STOP_LAP: begin
                if (s_req_type == lsc_pkg::EV_STARTSTOP) begin
                    mode_next  = lsc_pkg::MODE_RUN_LAP;
                    start_next = paused + start_reg;
                    lap_next   = paused + lap_reg;
                end else if (s_req_type == lsc_pkg::EV_LAPRESET) begin
                    mode_next = lsc_pkg::MODE_STOP;
                end
            end
            lsc_pkg::MODE_STOP: begin
                if (s_req_type == lsc_pkg::EV_STARTSTOP) begin
                    mode_next  = lsc_pkg::MODE_RUN;
                    start_next = paused + start_reg;
                end else if (s_req_type == lsc_pkg::EV_LAPRESET) begin
                    mode_next = lsc_pkg::MODE_IDLE;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    // operands of the shown time after the update
    always_comb begin
        evt_next.mode  = mode_next;
        evt_next.phase = s_tick_phase;
        evt_next.slow  = slow_next;
        unique case (mode_next)
            lsc_pkg::MODE_RUN: begin
                evt_next.minuend    = s_counter_now;
                evt_next.subtrahend = start_next;
            end
            lsc_pkg::MODE_RUN_LAP, lsc_pkg::MODE_STOP_LAP: begin
                evt_next.minuend    = lap_next;
                evt_next.subtrahend = start_next;
            end
            lsc_pkg::MODE_STOP: begin
                evt_next.minuend    = stop_next;
                evt_next.subtrahend = start_next;
            end
            default: begin
                evt_next.minuend    = 32'd0;
                evt_next.subtrahend = 32'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= lsc_pkg::MODE_IDLE;
            start_reg     <= 32'd0;
            stop_reg      <= 32'd0;
            lap_reg       <= 32'd0;
            slow_reg      <= 1'b0;
            evt_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                stop_reg  <= stop_next;
                lap_reg   <= lap_next;
                slow_reg  <= slow_next;
            end
            if (s_ready) begin
                evt_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            evt_reg <= evt_next;
        end
    end

endmodule

### hw/rtl/lsc_time_split.sv
// lsc_time_split: pipeline that splits shown ticks into display fields
module lsc_time_split (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            evt_valid,
    output logic            evt_ready,
    input  lsc_pkg::event_t evt,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_mode,
    output logic [31:0]     m_elapsed_ticks,
    output logic [6:0]      m_hundredths,
    output logic            m_hundredths_blank,
    output logic [5:0]      m_seconds_part,
    output logic [5:0]      m_minutes_part,
    output logic [4:0]      m_hours_part,
    output logic            m_lap_indicator,
    output logic            m_colon_on,
    output logic [5:0]      m_refresh_rate
);

    typedef struct packed {
        lsc_pkg::mode_t mode;
        logic           lap;
        logic           colon;
        logic [5:0]     rate;
        logic           blank;
    } flags_t;

    localparam logic [25:0] DIV60_MULT = 26'd35791395;
    localparam logic [11:0] DIV3_MULT  = 12'd2731;
    localparam logic [6:0]  HUND_SCALE = 7'd100;

    // floor(x / 60), exact for any 25-bit x
    function automatic logic [19:0] div60(input logic [24:0] x);
        logic [50:0] prod;
        prod = {26'd0, x} * {25'd0, DIV60_MULT};
        return prod[50:31];
    endfunction

    // stage valids
    logic v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic r2, r3, r4, r5, r6;

    // stage 2
    logic [31:0] el2_reg;
    flags_t      fl2_reg, fl2_next;
    logic [31:0] el2_next;
    // stage 3
    logic [31:0] el3_reg;
    flags_t      fl3_reg;
    logic [6:0]  hund3_reg;
    logic [19:0] mins3_reg;
    logic [13:0] hund_prod;
    // stage 4
    logic [31:0] el4_reg;
    flags_t      fl4_reg;
    logic [6:0]  hund4_reg;
    logic [19:0] mins4_reg;
    logic [5:0]  sec4_reg;
    logic [13:0] hours4_reg;
    logic [24:0] sec_rem;
    logic [19:0] hours_q;
    // stage 5
    logic [31:0] el5_reg;
    flags_t      fl5_reg;
    logic [6:0]  hund5_reg;
    logic [5:0]  sec5_reg;
    logic [5:0]  min5_reg;
    logic [13:0] hours5_reg;
    logic [9:0]  q3_5_reg;
    logic [19:0] min_rem;
    logic [22:0] div3_prod;
    // stage 6
    logic [31:0] el6_reg;
    flags_t      fl6_reg;
    logic [6:0]  hund6_reg;
    logic [5:0]  sec6_reg;
    logic [5:0]  min6_reg;
    logic [4:0]  hours6_reg;
    logic [10:0] t5;
    logic [10:0] mod3_rem;

    assign r6        = !v6_reg || m_ready;
    assign r5        = !v5_reg || r6;
    assign r4        = !v4_reg || r5;
    assign r3        = !v3_reg || r4;
    assign r2        = !v2_reg || r3;
    assign evt_ready = r2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (r2) v2_reg <= evt_valid;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // stage 2: shown time and indicators
    assign el2_next = evt.minuend - evt.subtrahend;

    always_comb begin
        fl2_next.mode  = evt.mode;
        fl2_next.blank = evt.slow &&
                         (evt.mode == lsc_pkg::MODE_RUN || evt.mode == lsc_pkg::MODE_IDLE);
        unique case (evt.mode)
            lsc_pkg::MODE_RUN: begin
                fl2_next.lap   = 1'b0;
                fl2_next.colon = !el2_next[6];
                fl2_next.rate  = evt.slow ? lsc_pkg::RATE_SLOW : lsc_pkg::RATE_FAST;
            end
            lsc_pkg::MODE_RUN_LAP: begin
                fl2_next.lap   = (evt.phase == 7'd0);
                fl2_next.colon = (evt.phase == 7'd0);
                fl2_next.rate  = lsc_pkg::RATE_LAP;
            end
            lsc_pkg::MODE_STOP_LAP: begin
                fl2_next.lap   = 1'b1;
                fl2_next.colon = 1'b1;
                fl2_next.rate  = lsc_pkg::RATE_IDLE;
            end
            default: begin
                fl2_next.lap   = 1'b0;
                fl2_next.colon = 1'b1;
                fl2_next.rate  = lsc_pkg::RATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (r2 && evt_valid) begin
            el2_reg <= el2_next;
            fl2_reg <= fl2_next;
        end
    end

    // stage 3: hundredths and total minutes
    assign hund_prod = {7'd0, el2_reg[6:0]} * {7'd0, HUND_SCALE};

    always_ff @(posedge aclk) begin
        if (r3 && v2_reg) begin
            el3_reg   <= el2_reg;
            fl3_reg   <= fl2_reg;
            hund3_reg <= hund_prod[13:7];
            mins3_reg <= div60(el2_reg[31:7]);
        end
    end

    // stage 4: seconds within minute and total hours
    assign sec_rem = el3_reg[31:7] - ({mins3_reg[18:0], 6'd0} - {3'd0, mins3_reg, 2'd0});
    assign hours_q = div60({5'd0, mins3_reg});

    always_ff @(posedge aclk) begin
        if (r4 && v3_reg) begin
            el4_reg    <= el3_reg;
            fl4_reg    <= fl3_reg;
            hund4_reg  <= hund3_reg;
            mins4_reg  <= mins3_reg;
            sec4_reg   <= sec_rem[5:0];
            hours4_reg <= hours_q[13:0];
        end
    end

    // stage 5: minutes within hour, hours / 24 via (hours / 8) / 3
    assign min_rem   = mins4_reg -
                       ({hours4_reg, 6'd0} - {4'd0, hours4_reg, 2'd0});
    assign div3_prod = {12'd0, hours4_reg[13:3]} * {11'd0, DIV3_MULT};

    always_ff @(posedge aclk) begin
        if (r5 && v4_reg) begin
            el5_reg    <= el4_reg;
            fl5_reg    <= fl4_reg;
            hund5_reg  <= hund4_reg;
            sec5_reg   <= sec4_reg;
            min5_reg   <= min_rem[5:0];
            hours5_reg <= hours4_reg;
            q3_5_reg   <= div3_prod[22:13];
        end
    end

    // stage 6: hours mod 24 and result register
    assign t5       = hours5_reg[13:3];
    assign mod3_rem = t5 - ({q3_5_reg, 1'b0} + {1'b0, q3_5_reg});

    always_ff @(posedge aclk) begin
        if (r6 && v5_reg) begin
            el6_reg    <= el5_reg;
            fl6_reg    <= fl5_reg;
            hund6_reg  <= hund5_reg;
            sec6_reg   <= sec5_reg;
            min6_reg   <= min5_reg;
            hours6_reg <= {mod3_rem[1:0], hours5_reg[2:0]};
        end
    end

    assign m_valid            = v6_reg;
    assign m_mode             = fl6_reg.mode;
    assign m_elapsed_ticks    = el6_reg;
    assign m_hundredths       = hund6_reg;
    assign m_hundredths_blank = fl6_reg.blank;
    assign m_seconds_part     = sec6_reg;
    assign m_minutes_part     = min6_reg;
    assign m_hours_part       = hours6_reg;
    assign m_lap_indicator    = fl6_reg.lap;
    assign m_colon_on         = fl6_reg.colon;
    assign m_refresh_rate     = fl6_reg.rate;

endmodule

### hw/rtl/lap_stopwatch_controller.sv
// lap_stopwatch_controller: top level of the lap stopwatch controller
//
// One request (tick, activate, start/stop, lap/reset or long press, with the
// current 128 Hz counter value) updates the mode and the start, stop and lap
// marks in the cycle it is accepted and yields exactly one result, valid on
// m_valid once it has passed the event register and pipeline stages 2 to 6,
// describing the display after that request. A new request can be accepted
// every cycle, also while a result waits on m_ready, until six requests are
// held in the pipeline; the latency is set by the chain of reciprocal
// multiplies that splits the elapsed ticks into seconds, minutes and hours, at
// most one such multiply per pipeline stage. Mark arithmetic wraps modulo
// 2^32, hours wrap at 24, and no initialization pass follows reset.
module lap_stopwatch_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_counter_now,
    input  logic [6:0]  s_tick_phase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_mode,
    output logic [31:0] m_elapsed_ticks,
    output logic [6:0]  m_hundredths,
    output logic        m_hundredths_blank,
    output logic [5:0]  m_seconds_part,
    output logic [5:0]  m_minutes_part,
    output logic [4:0]  m_hours_part,
    output logic        m_lap_indicator,
    output logic        m_colon_on,
    output logic [5:0]  m_refresh_rate
);

    logic            evt_valid;
    logic            evt_ready;
    lsc_pkg::event_t evt;

    lsc_mode_ctrl u_mode_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_counter_now (s_counter_now),
        .s_tick_phase  (s_tick_phase),
        .evt_valid     (evt_valid),
        .evt_ready     (evt_ready),
        .evt           (evt)
    );

    lsc_time_split u_time_split (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .evt_valid          (evt_valid),
        .evt_ready          (evt_ready),
        .evt                (evt),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mode             (m_mode),
        .m_elapsed_ticks    (m_elapsed_ticks),
        .m_hundredths       (m_hundredths),
        .m_hundredths_blank (m_hundredths_blank),
        .m_seconds_part     (m_seconds_part),
        .m_minutes_part     (m_minutes_part),
        .m_hours_part       (m_hours_part),
        .m_lap_indicator    (m_lap_indicator),
        .m_colon_on         (m_colon_on),
        .m_refresh_rate     (m_refresh_rate)
    );

endmodule
